FILE: hw/rtl/sliding_window_median_filter_defines.svh
// Assertion helpers shared by the files that carry checks.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SWMF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swmf: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SWMF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swmf: next-cycle check failed");

`endif

FILE: hw/rtl/swmf_pkg.sv
package swmf_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CFG_VALUE_BITS = 7;

   // Register index, taken from the word address bit of the port.
   localparam logic REG_WINDOW_SIZE = 1'b0;

   // Window size lower limit and reset value.
   localparam int WIN_RESET = 5;
   localparam int WIN_MIN   = 3;

   // Input operation codes.
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Commands from the controller to the datapath.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_LOAD,
      CMD_SCAN,
      CMD_COMMIT
   } swmf_op_type;

   typedef struct packed {
      swmf_op_type op;
      logic        clear;
   } swmf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } swmf_status_type;

endpackage

FILE: hw/rtl/swmf_ram.sv
module swmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/swmf_ctrl.sv
module swmf_ctrl
   import swmf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_operation,
   input  swmf_status_type status,
   output logic            req_stall,
   output swmf_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      stall_ff;
   logic      clear_ff;

   // State, input stall and the latched operation kind.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
         clear_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  stall_ff <= 1'b1;
                  clear_ff <= (req_operation == OP_CLEAR);
                  state_ff <= (req_operation == OP_CLEAR) ? ST_FINISH : ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (status.out_free) begin
                  stall_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               stall_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Command decode for the datapath.
   always_comb begin
      cmd.clear = clear_ff;
      case (state_ff)
         ST_IDLE:   cmd.op = req_valid ? CMD_START : CMD_NONE;
         ST_LOAD:   cmd.op = CMD_LOAD;
         ST_SCAN:   cmd.op = CMD_SCAN;
         ST_FINISH: cmd.op = status.out_free ? CMD_COMMIT : CMD_NONE;
         default:   cmd.op = CMD_NONE;
      endcase
   end

   assign req_stall = stall_ff;

endmodule

FILE: hw/rtl/swmf_datapath.sv
module swmf_datapath
   import swmf_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swmf_cmd_type                          cmd,
   output swmf_status_type                       status,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS:0]           rsp_median_x2,
   output logic [$clog2(MAX_WINDOW+1)-1:0]       rsp_fill_count,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [CSR_ADDR_BITS-1:0]              paddr,
   input  logic [CSR_DATA_BITS-1:0]              pwdata,
   output logic [CSR_DATA_BITS-1:0]              prdata,
   output logic                                  pready
);

   localparam int CW   = $clog2(MAX_WINDOW + 1);
   localparam int IW   = $clog2(MAX_WINDOW);
   localparam int SATW = (CW > CFG_VALUE_BITS) ? CW : CFG_VALUE_BITS;

   // Control and window state.
   logic [CW-1:0] win_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] oldest_ff;
   logic [IW-1:0] next_oldest_ff;
   logic          bank_ff;

   // Per-transaction working registers.
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic signed [SAMPLE_BITS-1:0] lo_ff;
   logic signed [SAMPLE_BITS-1:0] hi_ff;
   logic [CW-1:0] r_ff;
   logic [CW-1:0] w_ff;
   logic          ins_ff;
   logic          del_ff;
   logic          full_ff;

   // Result register.
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS:0]   med_ff;
   logic [CW-1:0]                 fill_ff;

   // Memory connections.
   logic                   ring_we;
   logic [IW-1:0]          ring_waddr;
   logic [IW-1:0]          ring_raddr;
   logic [SAMPLE_BITS-1:0] ring_rdata;
   logic                   sort_we;
   logic [IW:0]            sort_waddr;
   logic [IW:0]            sort_raddr;
   logic [SAMPLE_BITS-1:0] sort_wdata;
   logic [SAMPLE_BITS-1:0] sort_rdata;

   // Combinational helpers.
   logic                          full_now;
   logic [IW-1:0]                 oldest_cur;
   logic [IW-1:0]                 slot;
   logic [CW-1:0]                 slot_next;
   logic [CW-1:0]                 n_new;
   logic [CW-1:0]                 mid_lo;
   logic [CW-1:0]                 mid_hi;
   logic signed [SAMPLE_BITS-1:0] x;
   logic                          exhausted;
   logic                          emit;
   logic signed [SAMPLE_BITS-1:0] emit_val;
   logic                          advance;
   logic                          set_ins;
   logic                          set_del;
   logic [CW-1:0]                 r_next;
   logic                          out_free;
   logic                          cfg_write;
   logic [SATW-1:0]               win_sat;
   logic signed [SAMPLE_BITS:0]   med_in;

   // Ring slot for the new sample; the oldest pointer wraps at the window size.
   always_comb begin
      full_now   = (count_ff == win_ff);
      oldest_cur = (CW'(oldest_ff) >= win_ff) ? '0 : oldest_ff;
      slot       = full_now ? oldest_cur : count_ff[IW-1:0];
      slot_next  = CW'(slot) + CW'(1);
   end

   // Size of the new window and the two middle positions of the sorted list.
   always_comb begin
      n_new  = full_ff ? count_ff : count_ff + CW'(1);
      mid_hi = n_new >> 1;
      mid_lo = (n_new - CW'(1)) >> 1;
   end

   // Merge step: drop the evicted value once and insert the new one in order.
   always_comb begin
      x         = $signed(sort_rdata);
      exhausted = (r_ff == count_ff);
      emit      = 1'b0;
      emit_val  = x;
      advance   = 1'b0;
      set_ins   = 1'b0;
      set_del   = 1'b0;
      if (exhausted) begin
         if (!ins_ff) begin
            emit     = 1'b1;
            emit_val = sample_ff;
            set_ins  = 1'b1;
         end
      end else if (!ins_ff && (sample_ff < x)) begin
         emit     = 1'b1;
         emit_val = sample_ff;
         set_ins  = 1'b1;
      end else if (full_ff && !del_ff && (x == old_ff)) begin
         set_del = 1'b1;
         advance = 1'b1;
      end else begin
         emit    = 1'b1;
         advance = 1'b1;
      end
   end

   // Read address of the sorted list for the next cycle.
   always_comb begin
      if (cmd.op == CMD_LOAD) begin
         r_next = '0;
      end else if ((cmd.op == CMD_SCAN) && advance) begin
         r_next = r_ff + CW'(1);
      end else begin
         r_next = r_ff;
      end
   end

   // Memory control: ring written on load, sorted list written in the other bank.
   assign ring_we    = (cmd.op == CMD_LOAD);
   assign ring_waddr = slot;
   assign ring_raddr = oldest_cur;
   assign sort_we    = (cmd.op == CMD_SCAN) && emit;
   assign sort_waddr = {~bank_ff, w_ff[IW-1:0]};
   assign sort_wdata = emit_val;
   assign sort_raddr = {bank_ff, r_next[IW-1:0]};

   swmf_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(MAX_WINDOW)
   ) u_ring (
      .clock(clock),
      .we(ring_we),
      .waddr(ring_waddr),
      .wdata(sample_ff),
      .raddr(ring_raddr),
      .rdata(ring_rdata)
   );

   // Each bank spans the full index range so the bank bit addresses it cleanly.
   swmf_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(2 ** (IW + 1))
   ) u_sorted (
      .clock(clock),
      .we(sort_we),
      .waddr(sort_waddr),
      .wdata(sort_wdata),
      .raddr(sort_raddr),
      .rdata(sort_rdata)
   );

   // Configuration write with saturation of the window size.
   always_comb begin
      cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
      win_sat   = SATW'(pwdata[CFG_VALUE_BITS-1:0]);
      if (win_sat < SATW'(WIN_MIN)) begin
         win_sat = SATW'(WIN_MIN);
      end
      if (win_sat > SATW'(MAX_WINDOW)) begin
         win_sat = SATW'(MAX_WINDOW);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign med_in   = {lo_ff[SAMPLE_BITS-1], lo_ff} + {hi_ff[SAMPLE_BITS-1], hi_ff};

   // Window state, configuration and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= CW'(WIN_RESET);
         count_ff     <= '0;
         oldest_ff    <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ins_ff       <= 1'b0;
         del_ff       <= 1'b0;
      end else begin
         if (cfg_write) begin
            win_ff    <= CW'(win_sat);
            count_ff  <= '0;
            oldest_ff <= '0;
         end
         if (cmd.op == CMD_LOAD) begin
            ins_ff <= 1'b0;
            del_ff <= 1'b0;
         end
         if (cmd.op == CMD_SCAN) begin
            if (set_ins) begin
               ins_ff <= 1'b1;
            end
            if (set_del) begin
               del_ff <= 1'b1;
            end
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == CMD_COMMIT) begin
            rsp_valid_ff <= 1'b1;
            if (cmd.clear) begin
               count_ff  <= '0;
               oldest_ff <= '0;
            end else begin
               count_ff <= n_new;
               bank_ff  <= ~bank_ff;
               if (full_ff) begin
                  oldest_ff <= next_oldest_ff;
               end
            end
         end
      end
   end

   // Payload registers of the transaction in flight.
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_START) begin
         sample_ff <= req_sample;
      end
      if (cmd.op == CMD_LOAD) begin
         old_ff         <= $signed(ring_rdata);
         full_ff        <= full_now;
         next_oldest_ff <= (slot_next >= win_ff) ? '0 : slot_next[IW-1:0];
         w_ff           <= '0;
      end
      r_ff <= r_next;
      if (sort_we) begin
         w_ff <= w_ff + CW'(1);
         if (w_ff == mid_lo) begin
            lo_ff <= emit_val;
         end
         if (w_ff == mid_hi) begin
            hi_ff <= emit_val;
         end
      end
      if (cmd.op == CMD_COMMIT) begin
         if (cmd.clear) begin
            med_ff  <= '0;
            fill_ff <= '0;
         end else begin
            med_ff  <= med_in;
            fill_ff <= n_new;
         end
      end
   end

   // Register read and status.
   assign prdata           = (paddr[2] == REG_WINDOW_SIZE) ? CSR_DATA_BITS'(win_ff) : '0;
   assign pready           = 1'b1;
   assign status.scan_done = exhausted;
   assign status.out_free  = out_free;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_x2    = med_ff;
   assign rsp_fill_count   = fill_ff;

endmodule

FILE: hw/rtl/sliding_window_median_filter.sv
// Running median over the most recent window_size samples.
// Request channel (req_valid, req_stall, req_operation, req_sample): a push
// transaction adds a sample, a clear transaction empties the window.
// Response channel (rsp_valid, rsp_stall, rsp_median_x2, rsp_fill_count):
// one transaction per request, giving twice the median of the samples held
// and how many are held; a clear answers with zero for both.
// A push runs through these steps: accept, a load step that reads the evicted
// ring entry, then a merge pass that reads the sorted entries in order from a
// ping-pong memory, and a finish step that writes the result. A clear goes
// from accept straight to the finish step.
// One request is in work at a time; req_stall is high from acceptance until
// the result lands in the output register, so the next request can be taken
// while that result still waits on rsp_stall.
// If the receiver stalls, the finished result holds and the block waits.
// Reset sets window_size to 5 and empties the window; no memory sweep is
// needed. Writing window_size (saturated to 3..MAX_WINDOW) also empties it,
// and must only be done while the block is idle.
`include "sliding_window_median_filter_defines.svh"

module sliding_window_median_filter
   import swmf_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS:0]        rsp_median_x2,
   output logic [$clog2(MAX_WINDOW+1)-1:0]    rsp_fill_count,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]           csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]           csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]           csr_prdata,
   output logic                               csr_pready
);

   swmf_cmd_type    cmd;
   swmf_status_type status;

   swmf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_operation(req_operation),
      .status(status),
      .req_stall(req_stall),
      .cmd(cmd)
   );

   swmf_datapath #(
      .MAX_WINDOW(MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_median_x2(rsp_median_x2),
      .rsp_fill_count(rsp_fill_count),
      .psel(csr_psel),
      .penable(csr_penable),
      .pwrite(csr_pwrite),
      .paddr(csr_paddr),
      .pwdata(csr_pwdata),
      .prdata(csr_prdata),
      .pready(csr_pready)
   );

   // An empty window always reports a zero median.
   `SWMF_ASSERT_IMP(a_empty_zero, rsp_valid && (rsp_fill_count == '0), rsp_median_x2 == '0)

   // The held count never goes beyond the largest window.
   `SWMF_ASSERT_IMP(a_fill_bound, rsp_valid, rsp_fill_count <= MAX_WINDOW)

   // A committed result shows up on the response channel in the next cycle.
   `SWMF_ASSERT_NXT(a_commit_shows, cmd.op == CMD_COMMIT, rsp_valid)

   // The merge pass only runs while the request side is held off.
   `SWMF_ASSERT_IMP(a_scan_stalled, cmd.op == CMD_SCAN, req_stall)

endmodule
